@@ rtl/core/stbs_pkg.sv @@
// Shared constants and types for the sorted table binary search unit.
package stbs_pkg;

   // Table geometry.
   localparam int DEPTH     = 1024;
   localparam int KEY_BITS  = 64;
   localparam int DATA_BITS = 64;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int REC_BYTES = (KEY_BITS + 7) / 8 + (DATA_BITS + 7) / 8;

   // Port field widths.
   localparam int CMD_W    = 2;
   localparam int SKEY_W   = 64;
   localparam int NDATA_W  = 64;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 10;
   localparam int OFFSET_W = 33;
   localparam int FDATA_W  = 64;
   localparam int ECOUNT_W = 11;
   localparam int BASE_W   = 32;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT   = 2'd0;
   localparam cmd_type CMD_FINALIZE = 2'd1;
   localparam cmd_type CMD_LOOKUP   = 2'd2;

   localparam status_type ST_OK    = 3'd0;
   localparam status_type ST_PHASE = 3'd1;
   localparam status_type ST_ORDER = 3'd2;
   localparam status_type ST_MISS  = 3'd3;
   localparam status_type ST_FULL  = 3'd4;

endpackage

@@ rtl/core/stbs_if.sv @@
// Request and response channel interfaces of the sorted table binary search unit.
interface stbs_req_if;
   logic                            valid;
   logic                            ready;
   stbs_pkg::cmd_type               cmd;
   logic [stbs_pkg::SKEY_W-1:0]     search_key;
   logic [stbs_pkg::NDATA_W-1:0]    new_data;

   modport source (output valid, cmd, search_key, new_data, input ready);
   modport sink   (input valid, cmd, search_key, new_data, output ready);
endinterface

interface stbs_rsp_if;
   logic                            valid;
   logic                            ready;
   stbs_pkg::status_type            status;
   logic [stbs_pkg::FIDX_W-1:0]     found_index;
   logic [stbs_pkg::OFFSET_W-1:0]   record_offset;
   logic [stbs_pkg::FDATA_W-1:0]    found_data;
   logic [stbs_pkg::ECOUNT_W-1:0]   entry_count;

   modport source (output valid, status, found_index, record_offset, found_data,
                   entry_count, input ready);
   modport sink   (input valid, status, found_index, record_offset, found_data,
                   entry_count, output ready);
endinterface

@@ rtl/core/stbs_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module stbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sorted_table_binary_search_unit.sv @@
// Top level of the sorted table binary search unit: write-once sorted table with lookup.
//
//   channel  direction  handshake        payload
//   req_bus  in         valid / ready    cmd, search_key, new_data
//   rsp_bus  out        valid / ready    status, found_index, record_offset,
//                                        found_data, entry_count
//   csr      in         csr_wr_en        csr_wr_data (base offset)
//
// Insert, finalize and rejected requests go from S_IDLE to S_DONE, where the result is
// registered and then moved into the output register once that is free; the unit then
// returns to S_IDLE and can take the next request. A lookup probes the key memory by one
// read in S_PROBE and one compare in S_CMP per probe, until a hit or an empty range.
// One request is in work at a time; a finished response waits in the output
// register while the next request is accepted. Reset is synchronous and
// empties the table at once; the key and data memories are not cleared.
module sorted_table_binary_search_unit (
   input  logic                             clock,
   input  logic                             reset,
   stbs_req_if.sink                         req_bus,
   stbs_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [stbs_pkg::BASE_W-1:0]      csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PROBE = 4'b0010,
      S_CMP   = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   localparam int IDX_W = stbs_pkg::IDX_W;
   localparam int CNT_W = stbs_pkg::CNT_W;
   localparam int KB    = stbs_pkg::KEY_BITS;
   localparam int DB    = stbs_pkg::DATA_BITS;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [KB-1:0]                    last_key_ff, last_key_in;
   logic                             closed_ff, closed_in;
   logic [stbs_pkg::BASE_W-1:0]      base_ff, base_in;
   logic [KB-1:0]                    key_ff, key_in;
   logic [CNT_W-1:0]                 lo_ff, lo_in;
   logic [CNT_W-1:0]                 n_ff, n_in;
   logic [IDX_W-1:0]                 mid_ff, mid_in;

   stbs_pkg::status_type             res_status_ff, res_status_in;
   logic [stbs_pkg::FIDX_W-1:0]      res_index_ff, res_index_in;
   logic [stbs_pkg::OFFSET_W-1:0]    res_offset_ff, res_offset_in;
   logic [stbs_pkg::FDATA_W-1:0]     res_data_ff, res_data_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   stbs_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [stbs_pkg::FIDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [stbs_pkg::OFFSET_W-1:0]    rsp_offset_ff, rsp_offset_in;
   logic [stbs_pkg::FDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [stbs_pkg::ECOUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                             accept;
   logic [KB-1:0]                    req_key;
   logic [DB-1:0]                    req_data;
   logic                             table_full;
   logic                             key_in_order;
   logic                             insert_ok;
   logic [CNT_W-1:0]                 half;
   logic [CNT_W-1:0]                 mid_wide;
   logic [IDX_W-1:0]                 ram_addr;
   logic [KB-1:0]                    rd_key;
   logic [DB-1:0]                    rd_data;
   logic                             out_free;

   assign req_key      = req_bus.search_key[KB-1:0];
   assign req_data     = req_bus.new_data[DB-1:0];
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept       = req_bus.valid && req_bus.ready;

   assign table_full   = (count_ff >= CNT_W'(stbs_pkg::DEPTH));
   assign key_in_order = (count_ff == '0) || (last_key_ff < req_key);
   assign insert_ok    = accept && (req_bus.cmd == stbs_pkg::CMD_INSERT) && !closed_ff
                         && !table_full && key_in_order;

   assign half     = n_ff >> 1;
   assign mid_wide = lo_ff + half;

   // The single port of each memory writes on an insert and reads the probe address otherwise.
   assign ram_addr = (state_ff == S_IDLE) ? count_ff[IDX_W-1:0] : mid_wide[IDX_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   stbs_ram #(.WIDTH(KB), .DEPTH(stbs_pkg::DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (insert_ok),
      .addr    (ram_addr),
      .wr_data (req_key),
      .rd_data (rd_key)
   );

   stbs_ram #(.WIDTH(DB), .DEPTH(stbs_pkg::DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (insert_ok),
      .addr    (ram_addr),
      .wr_data (req_data),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_key_in   = last_key_ff;
      closed_in     = closed_ff;
      base_in       = csr_wr_en ? csr_wr_data : base_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      n_in          = n_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_offset_in = res_offset_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = stbs_pkg::ST_PHASE;
               res_index_in  = '0;
               res_offset_in = '0;
               res_data_in   = '0;
               state_in      = S_DONE;
               unique case (req_bus.cmd)
                  stbs_pkg::CMD_INSERT: begin
                     priority if (closed_ff) begin
                        res_status_in = stbs_pkg::ST_PHASE;
                     end else if (table_full) begin
                        res_status_in = stbs_pkg::ST_FULL;
                     end else if (!key_in_order) begin
                        res_status_in = stbs_pkg::ST_ORDER;
                     end else begin
                        res_status_in = stbs_pkg::ST_OK;
                        count_in      = count_ff + 1'b1;
                        last_key_in   = req_key;
                     end
                  end
                  stbs_pkg::CMD_FINALIZE: begin
                     if (!closed_ff) begin
                        closed_in     = 1'b1;
                        res_status_in = stbs_pkg::ST_OK;
                     end
                  end
                  stbs_pkg::CMD_LOOKUP: begin
                     if (closed_ff) begin
                        key_in   = req_key;
                        lo_in    = '0;
                        n_in     = count_ff;
                        state_in = S_PROBE;
                     end
                  end
                  default: begin
                     res_status_in = stbs_pkg::ST_PHASE;
                  end
               endcase
            end
         end
         S_PROBE: begin
            // The read of the middle entry is issued in this cycle.
            if (n_ff == '0) begin
               res_status_in = stbs_pkg::ST_MISS;
               state_in      = S_DONE;
            end else begin
               mid_in   = mid_wide[IDX_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            priority if (key_ff < rd_key) begin
               n_in     = half;
               state_in = S_PROBE;
            end else if (key_ff > rd_key) begin
               lo_in    = CNT_W'(mid_ff) + 1'b1;
               n_in     = n_ff - half - 1'b1;
               state_in = S_PROBE;
            end else begin
               res_status_in = stbs_pkg::ST_OK;
               res_index_in  = stbs_pkg::FIDX_W'(mid_ff);
               res_offset_in = stbs_pkg::OFFSET_W'(base_ff)
                               + stbs_pkg::OFFSET_W'(mid_ff)
                               * stbs_pkg::OFFSET_W'(stbs_pkg::REC_BYTES);
               res_data_in   = stbs_pkg::FDATA_W'(rd_data);
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_offset_in = res_offset_ff;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = stbs_pkg::ECOUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_key_ff  <= '0;
         closed_ff    <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_key_ff  <= last_key_in;
         closed_ff    <= closed_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      n_ff          <= n_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_offset_ff <= res_offset_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.found_index   = rsp_index_ff;
   assign rsp_bus.record_offset = rsp_offset_ff;
   assign rsp_bus.found_data    = rsp_data_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

endmodule

@@ rtl/core/stbs_checker.sv @@
// Port-level checker for the sorted table binary search unit, with its bind.
module stbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input stbs_pkg::status_type            rsp_status,
   input logic [stbs_pkg::FIDX_W-1:0]     rsp_found_index,
   input logic [stbs_pkg::OFFSET_W-1:0]   rsp_record_offset,
   input logic [stbs_pkg::FDATA_W-1:0]    rsp_found_data,
   input logic [stbs_pkg::ECOUNT_W-1:0]   rsp_entry_count
);

   // A stalled response keeps its valid and its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   // Only one request is in work, so the cycle after an accept is never ready.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // A response whose status is not OK carries zero in its lookup fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != stbs_pkg::ST_OK) |->
         (rsp_found_index == '0) && (rsp_record_offset == '0) && (rsp_found_data == '0))
      else $error("non-hit response carries lookup data");

   // The record count never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= stbs_pkg::ECOUNT_W'(stbs_pkg::DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_found_index   (rsp_bus.found_index),
   .rsp_record_offset (rsp_bus.record_offset),
   .rsp_found_data    (rsp_bus.found_data),
   .rsp_entry_count   (rsp_bus.entry_count)
);
